>>> src/csp_pkg.sv
`timescale 1ns / 1ps

package csp_pkg;

    localparam int WORD_W      = 32;
    localparam int INDEX_W     = 12;
    localparam int FILL_W      = 13;
    localparam int MATERIAL_W  = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int QUEUE_DEPTH = 2;

    // hard limit of the stream, applied on top of the capacity register
    localparam logic [FILL_W-1:0] STREAM_DEPTH = 13'd4096;

    localparam logic [WORD_W-1:0] SIGN_MASK    = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MAG_MASK     = 32'h7fff_ffff;
    localparam logic [15:0]       FEATURE_NONE = 16'hffff;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ORIENTED_TO        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STREAM_CAPACITY    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STREAM_START       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PAIR_COUNT_INDEX   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PAIR_COUNT_INITIAL = 3'd4;

    // classified contact, already in canonical order
    typedef struct packed {
        logic [WORD_W-1:0]     obj_a;
        logic [WORD_W-1:0]     obj_b;
        logic [MATERIAL_W-1:0] material;
        logic [WORD_W-1:0]     separation;
        logic [WORD_W-1:0]     point_x;
        logic [WORD_W-1:0]     point_y;
        logic [WORD_W-1:0]     point_z;
        logic [WORD_W-1:0]     normal_x;
        logic [WORD_W-1:0]     normal_y;
        logic [WORD_W-1:0]     normal_z;
        logic [WORD_W-1:0]     feature_word;
        logic                  new_pair;
        logic                  normal_change;
        logic                  has_features;
    } csp_item_t;

    // configuration seen by the back end
    typedef struct packed {
        logic [FILL_W-1:0]  capacity;
        logic [INDEX_W-1:0] pair_count_index;
        logic               fill_load;
        logic               count_load;
        logic [WORD_W-1:0]  load_value;
    } csp_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } csp_qstat_t;

    // back end sequencer steps
    typedef enum logic [14:0] {
        ST_OBJ_A     = 15'b000000000000001,
        ST_OBJ_B     = 15'b000000000000010,
        ST_HEADER    = 15'b000000000000100,
        ST_PAIR_CNT  = 15'b000000000001000,
        ST_NORMAL_X  = 15'b000000000010000,
        ST_NORMAL_Y  = 15'b000000000100000,
        ST_NORMAL_Z  = 15'b000000001000000,
        ST_PT_ZERO   = 15'b000000010000000,
        ST_HDR_CNT   = 15'b000000100000000,
        ST_POINT_X   = 15'b000001000000000,
        ST_POINT_Y   = 15'b000010000000000,
        ST_POINT_Z   = 15'b000100000000000,
        ST_SEP       = 15'b001000000000000,
        ST_PT_CNT    = 15'b010000000000000,
        ST_FEATURE   = 15'b100000000000000
    } csp_step_t;

endpackage

>>> src/csp_front.sv
`timescale 1ns / 1ps

module csp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [31:0]        oriented_to,
    input  logic [31:0]        first_object,
    input  logic [31:0]        second_object,
    input  logic [31:0]        owner_orientation,
    input  logic [7:0]         material,
    input  logic [31:0]        separation,
    input  logic [31:0]        point_x,
    input  logic [31:0]        point_y,
    input  logic [31:0]        point_z,
    input  logic [31:0]        normal_x,
    input  logic [31:0]        normal_y,
    input  logic [31:0]        normal_z,
    input  logic [31:0]        feature_pair,
    output csp_pkg::csp_item_t item
);
    import csp_pkg::*;

    logic [WORD_W-1:0] cached_a_reg;
    logic [WORD_W-1:0] cached_b_reg;
    logic [WORD_W-1:0] cached_nx_reg;
    logic [WORD_W-1:0] cached_ny_reg;
    logic [WORD_W-1:0] cached_nz_reg;
    logic              has_features_reg;

    logic              swap;
    logic [WORD_W-1:0] flip;
    logic [WORD_W-1:0] obj_a;
    logic [WORD_W-1:0] obj_b;
    logic [WORD_W-1:0] nx;
    logic [WORD_W-1:0] ny;
    logic [WORD_W-1:0] nz;
    logic              new_pair;
    logic              features_ok;
    logic              has_features_next;
    logic [WORD_W-1:0] ref_nx;
    logic [WORD_W-1:0] ref_ny;
    logic [WORD_W-1:0] ref_nz;

    assign swap  = owner_orientation != oriented_to;
    assign flip  = swap ? SIGN_MASK : '0;
    assign obj_a = swap ? second_object : first_object;
    assign obj_b = swap ? first_object : second_object;
    assign nx    = normal_x ^ flip;
    assign ny    = normal_y ^ flip;
    assign nz    = normal_z ^ flip;

    assign new_pair    = (cached_a_reg != obj_a) || (cached_b_reg != obj_b);
    assign features_ok = (feature_pair[15:0] != FEATURE_NONE)
                      && (feature_pair[31:16] != FEATURE_NONE);
    assign has_features_next = new_pair ? features_ok : has_features_reg;

    // a new pair clears the cached normal
    assign ref_nx = new_pair ? '0 : cached_nx_reg;
    assign ref_ny = new_pair ? '0 : cached_ny_reg;
    assign ref_nz = new_pair ? '0 : cached_nz_reg;

    always_comb
    begin
        item               = '0;
        item.obj_a         = obj_a;
        item.obj_b         = obj_b;
        item.material      = material;
        item.separation    = separation;
        item.point_x       = point_x;
        item.point_y       = point_y;
        item.point_z       = point_z;
        item.normal_x      = nx;
        item.normal_y      = ny;
        item.normal_z      = nz;
        item.feature_word  = swap ? {feature_pair[15:0], feature_pair[31:16]} : feature_pair;
        item.new_pair      = new_pair;
        item.normal_change = (ref_nx != nx) || (ref_ny != ny) || (ref_nz != nz);
        item.has_features  = has_features_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cached_a_reg     <= '0;
            cached_b_reg     <= '0;
            cached_nx_reg    <= '0;
            cached_ny_reg    <= '0;
            cached_nz_reg    <= '0;
            has_features_reg <= 1'b0;
        end
        else if (accept)
        begin
            cached_a_reg     <= obj_a;
            cached_b_reg     <= obj_b;
            cached_nx_reg    <= nx;
            cached_ny_reg    <= ny;
            cached_nz_reg    <= nz;
            has_features_reg <= has_features_next;
        end
    end

endmodule

>>> src/csp_queue.sv
`timescale 1ns / 1ps

module csp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  csp_pkg::csp_item_t  push_item,
    input  logic                pop,
    output csp_pkg::csp_item_t  head_item,
    output csp_pkg::csp_qstat_t stat
);
    import csp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    csp_item_t         entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign head_item  = entries_reg[rd_ptr_reg];
    assign stat.full  = count_reg == CNT_FULL;
    assign stat.empty = count_reg == '0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> src/csp_back.sv
`timescale 1ns / 1ps

module csp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  csp_pkg::csp_ctl_t  ctl,
    input  logic               head_valid,
    input  csp_pkg::csp_item_t head_item,
    output logic               pop,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [11:0]        word_index,
    output logic [31:0]        word_value,
    output logic               last,
    output logic [31:0]        contacts_total
);
    import csp_pkg::*;

    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [FILL_W-1:0]  header_index_reg;
    logic [FILL_W-1:0]  header_index_next;
    logic [FILL_W-1:0]  point_index_reg;
    logic [FILL_W-1:0]  point_index_next;
    logic [WORD_W-1:0]  pair_count_reg;
    logic [WORD_W-1:0]  pair_count_next;
    logic [WORD_W-1:0]  header_word_reg;
    logic [WORD_W-1:0]  header_word_next;
    logic [WORD_W-1:0]  point_count_reg;
    logic [WORD_W-1:0]  point_count_next;
    logic [WORD_W-1:0]  counter_reg;
    logic [WORD_W-1:0]  counter_next;
    csp_step_t          step_reg;
    csp_step_t          step_next;
    logic               active_reg;
    logic               active_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [INDEX_W-1:0] word_index_reg;
    logic [WORD_W-1:0]  word_value_reg;
    logic               last_reg;
    logic [WORD_W-1:0]  contacts_total_reg;

    logic [FILL_W-1:0]  cap_eff;
    logic               room1;
    logic               room3;
    logic               out_free;
    logic               go;
    csp_step_t          first_step;
    csp_step_t          cur_step;
    csp_step_t          after;
    logic               done;
    logic               emit;
    logic [INDEX_W-1:0] emit_index;
    logic [WORD_W-1:0]  emit_value;
    logic               emit_last;
    logic [WORD_W-1:0]  header_new;

    assign cap_eff  = (ctl.capacity > STREAM_DEPTH) ? STREAM_DEPTH : ctl.capacity;
    assign room1    = fill_reg < cap_eff;
    assign room3    = ({1'b0, fill_reg} + (FILL_W + 1)'(3)) <= {1'b0, cap_eff};
    assign out_free = !out_valid_reg || !out_stall;
    assign go       = head_valid && out_free;

    assign first_step = head_item.new_pair      ? ST_OBJ_A :
                        head_item.normal_change ? ST_NORMAL_X : ST_POINT_X;
    assign cur_step   = active_reg ? step_reg : first_step;
    assign header_new = {head_item.material, 7'd0, head_item.has_features, 16'd0};

    always_comb
    begin
        after             = cur_step;
        done              = 1'b0;
        emit              = 1'b0;
        emit_index        = fill_reg[INDEX_W-1:0];
        emit_value        = '0;
        emit_last         = 1'b0;
        fill_next         = fill_reg;
        header_index_next = header_index_reg;
        point_index_next  = point_index_reg;
        pair_count_next   = pair_count_reg;
        header_word_next  = header_word_reg;
        point_count_next  = point_count_reg;

        case (cur_step)
            ST_OBJ_A:
            begin
                emit       = room1;
                emit_value = head_item.obj_a;
                after      = ST_OBJ_B;
            end
            ST_OBJ_B:
            begin
                emit       = room1;
                emit_value = head_item.obj_b;
                after      = ST_HEADER;
            end
            ST_HEADER:
            begin
                header_index_next = fill_reg;
                header_word_next  = header_new;
                emit              = room1;
                emit_value        = header_new;
                after             = ST_PAIR_CNT;
            end
            ST_PAIR_CNT:
            begin
                pair_count_next = pair_count_reg + 1'b1;
                emit            = 1'b1;
                emit_index      = ctl.pair_count_index;
                emit_value      = pair_count_reg + 1'b1;
                after           = head_item.normal_change ? ST_NORMAL_X : ST_POINT_X;
            end
            ST_NORMAL_X:
            begin
                emit       = room3;
                emit_value = head_item.normal_x;
                after      = room3 ? ST_NORMAL_Y : ST_PT_ZERO;
            end
            ST_NORMAL_Y:
            begin
                emit       = 1'b1;
                emit_value = head_item.normal_y;
                after      = ST_NORMAL_Z;
            end
            ST_NORMAL_Z:
            begin
                emit       = 1'b1;
                emit_value = head_item.normal_z;
                after      = ST_PT_ZERO;
            end
            ST_PT_ZERO:
            begin
                point_index_next = fill_reg;
                point_count_next = '0;
                emit             = room1;
                emit_value       = '0;
                after            = ST_HDR_CNT;
            end
            ST_HDR_CNT:
            begin
                header_word_next = header_word_reg + 1'b1;
                emit             = 1'b1;
                emit_index       = header_index_reg[INDEX_W-1:0];
                emit_value       = header_word_reg + 1'b1;
                after            = ST_POINT_X;
            end
            ST_POINT_X:
            begin
                emit       = room3;
                emit_value = head_item.point_x;
                after      = room3 ? ST_POINT_Y : ST_SEP;
            end
            ST_POINT_Y:
            begin
                emit       = 1'b1;
                emit_value = head_item.point_y;
                after      = ST_POINT_Z;
            end
            ST_POINT_Z:
            begin
                emit       = 1'b1;
                emit_value = head_item.point_z;
                after      = ST_SEP;
            end
            ST_SEP:
            begin
                emit       = room1;
                emit_value = head_item.separation & MAG_MASK;
                after      = ST_PT_CNT;
            end
            ST_PT_CNT:
            begin
                // feature word follows only when it has room
                point_count_next = point_count_reg + 1'b1;
                emit             = 1'b1;
                emit_index       = point_index_reg[INDEX_W-1:0];
                emit_value       = point_count_reg + 1'b1;
                emit_last        = !(head_item.has_features && room1);
                done             = emit_last;
                after            = ST_FEATURE;
            end
            ST_FEATURE:
            begin
                emit       = 1'b1;
                emit_value = head_item.feature_word;
                emit_last  = 1'b1;
                done       = 1'b1;
            end
            default:
            begin
                done = 1'b1;
            end
        endcase

        // stream words advance the fill level, count rewrites do not
        if (emit && (emit_index == fill_reg[INDEX_W-1:0]) && (cur_step != ST_PAIR_CNT)
            && (cur_step != ST_HDR_CNT) && (cur_step != ST_PT_CNT))
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_comb
    begin
        pop            = go && done;
        step_next      = step_reg;
        active_next    = active_reg;
        counter_next   = counter_reg;
        out_valid_next = out_valid_reg;
        if (go)
        begin
            if (done)
            begin
                active_next  = 1'b0;
                counter_next = counter_reg + 1'b1;
            end
            else
            begin
                active_next = 1'b1;
                step_next   = after;
            end
        end
        if (go && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg         <= '0;
            header_index_reg <= '0;
            point_index_reg  <= '0;
            pair_count_reg   <= '0;
            header_word_reg  <= '0;
            point_count_reg  <= '0;
            counter_reg      <= '0;
            step_reg         <= ST_POINT_X;
            active_reg       <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.fill_load)
            begin
                fill_reg <= ctl.load_value[FILL_W-1:0];
            end
            else if (go)
            begin
                fill_reg <= fill_next;
            end
            if (ctl.count_load)
            begin
                pair_count_reg <= ctl.load_value;
            end
            else if (go)
            begin
                pair_count_reg <= pair_count_next;
            end
            if (go)
            begin
                header_index_reg <= header_index_next;
                point_index_reg  <= point_index_next;
                header_word_reg  <= header_word_next;
                point_count_reg  <= point_count_next;
            end
            counter_reg   <= counter_next;
            step_reg      <= step_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && emit)
        begin
            word_index_reg     <= emit_index;
            word_value_reg     <= emit_value;
            last_reg           <= emit_last;
            contacts_total_reg <= counter_reg + 1'b1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign word_index     = word_index_reg;
    assign word_value     = word_value_reg;
    assign last           = last_reg;
    assign contacts_total = contacts_total_reg;

endmodule

>>> src/contact_stream_packer.sv
`timescale 1ns / 1ps

// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+------------------------------------------
// in       | in        | in_valid / in_stall   | one contact: objects, orientation, material,
//          |           |                       | separation, point, normal, feature pair
// out      | out       | out_valid / out_stall | one stream word: word_index, word_value,
//          |           |                       | last, contacts_total
// cfg      | in        | cfg_write             | cfg_index, cfg_data
//
// back end: one sequencer step per cycle while out_stall does not hold it; pair header four steps,
// normal block five, point record three to six; a dropped triple is one step
// the front end takes an item every cycle until the two-entry queue is full
// rst_n is asynchronous: fill level 0, pair count 0, capacity 4096, all caches cleared
// out_stall only freezes the output register and the sequencer; the front keeps filling
// the queue, and in_stall rises only when the queue is full

module contact_stream_packer (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] first_object,
    input  logic [31:0] second_object,
    input  logic [31:0] owner_orientation,
    input  logic [7:0]  material,
    input  logic [31:0] separation,
    input  logic [31:0] point_x,
    input  logic [31:0] point_y,
    input  logic [31:0] point_z,
    input  logic [31:0] normal_x,
    input  logic [31:0] normal_y,
    input  logic [31:0] normal_z,
    input  logic [31:0] feature_pair,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] word_index,
    output logic [31:0] word_value,
    output logic        last,
    output logic [31:0] contacts_total,

    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import csp_pkg::*;

    // configuration registers kept here; start and initial count only load back end state
    logic [WORD_W-1:0]  oriented_to_reg;
    logic [FILL_W-1:0]  capacity_reg;
    logic [INDEX_W-1:0] pair_count_index_reg;

    csp_ctl_t   ctl;
    csp_item_t  front_item;
    csp_item_t  head_item;
    csp_qstat_t q_stat;
    logic       in_accept;
    logic       q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oriented_to_reg      <= '0;
            capacity_reg         <= STREAM_DEPTH;
            pair_count_index_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ORIENTED_TO:      oriented_to_reg      <= cfg_data;
                REG_STREAM_CAPACITY:  capacity_reg         <= cfg_data[FILL_W-1:0];
                REG_PAIR_COUNT_INDEX: pair_count_index_reg <= cfg_data[INDEX_W-1:0];
                default:
                begin
                    // start and initial count go straight to the back end; others ignored
                end
            endcase
        end
    end

    always_comb
    begin
        ctl.capacity         = capacity_reg;
        ctl.pair_count_index = pair_count_index_reg;
        ctl.fill_load        = cfg_write && (cfg_index == REG_STREAM_START);
        ctl.count_load       = cfg_write && (cfg_index == REG_PAIR_COUNT_INITIAL);
        ctl.load_value       = cfg_data;
    end

    // input side stalls only on a full queue
    assign in_stall  = q_stat.full;
    assign in_accept = in_valid && !in_stall;

    // swap to canonical order and compare against cached pair and normal
    csp_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (in_accept),
        .oriented_to       (oriented_to_reg),
        .first_object      (first_object),
        .second_object     (second_object),
        .owner_orientation (owner_orientation),
        .material          (material),
        .separation        (separation),
        .point_x           (point_x),
        .point_y           (point_y),
        .point_z           (point_z),
        .normal_x          (normal_x),
        .normal_y          (normal_y),
        .normal_z          (normal_z),
        .feature_pair      (feature_pair),
        .item              (front_item)
    );

    // classified items waiting for the sequencer
    csp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_item (front_item),
        .pop       (q_pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    // word sequencer, stream fill, count words and output register
    csp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .head_valid     (!q_stat.empty),
        .head_item      (head_item),
        .pop            (q_pop),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .word_index     (word_index),
        .word_value     (word_value),
        .last           (last),
        .contacts_total (contacts_total)
    );

    // queue bookkeeping
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> !q_stat.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_status_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");

    // every finished contact ends with a word flagged last
    a_pop_sets_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (out_valid && last))
        else $error("contact finished without last word");

endmodule
